// ===== rtl/mbrc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the Modbus reply checker.
package mbrc_pkg;

	localparam int FRAME_BYTES    = 11;
	localparam int REGISTER_COUNT = 3;
	localparam int PAYLOAD_DEPTH  = 2 * REGISTER_COUNT;
	localparam int HEADER_BYTES   = 3;

	localparam logic [3:0]  COUNT_MAX   = 4'd15;
	localparam logic [3:0]  COUNT_FRAME = 4'(FRAME_BYTES);
	localparam logic [7:0]  COUNT_BYTE  = 8'(2 * REGISTER_COUNT);
	localparam logic [15:0] CRC_START   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;

	// word opcodes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_EOF  = 1'b1;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TIMEOUT  = 3'd1;
	localparam logic [2:0] ST_LENGTH   = 3'd2;
	localparam logic [2:0] ST_CRC      = 3'd3;
	localparam logic [2:0] ST_UNIT     = 3'd4;
	localparam logic [2:0] ST_FUNCTION = 3'd5;

	// register indexes (byte address bit 2)
	localparam logic REG_UNIT     = 1'b0;
	localparam logic REG_FUNCTION = 1'b1;

	localparam logic [8:0] UNIT_RESET     = 9'd1;
	localparam logic [8:0] FUNCTION_RESET = 9'd3;

	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_byte;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] first_reading;
		logic [15:0] second_reading;
		logic [15:0] third_reading;
	} out_word_t;

	typedef struct packed {
		logic byte_en;
		logic eof_en;
	} frame_ctl_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] v;
		v = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
		end
		return v;
	endfunction

endpackage

// ===== rtl/mbrc_frame.sv =====
// Frame state of the reply checker: running CRC, byte count, header flags, data bytes.
module mbrc_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mbrc_pkg::frame_ctl_t  ctl,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            unit_address,
	input  logic [7:0]            function_code,
	output mbrc_pkg::out_word_t   result
);
	import mbrc_pkg::*;

	logic [15:0] crc_q;
	logic [3:0]  count_q;
	logic        unit_ok_q;
	logic        func_ok_q;
	logic        count_ok_q;
	logic [7:0]  payload_q [PAYLOAD_DEPTH];

	logic [3:0]  slot;
	logic        slot_hit;
	logic [2:0]  status;

	assign slot     = count_q - 4'(HEADER_BYTES);
	assign slot_hit = (count_q >= 4'(HEADER_BYTES))
		&& (count_q < 4'(HEADER_BYTES + PAYLOAD_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_START;
			count_q    <= '0;
			unit_ok_q  <= 1'b0;
			func_ok_q  <= 1'b0;
			count_ok_q <= 1'b0;
		end else if (ctl.eof_en) begin
			crc_q      <= CRC_START;
			count_q    <= '0;
			unit_ok_q  <= 1'b0;
			func_ok_q  <= 1'b0;
			count_ok_q <= 1'b0;
		end else if (ctl.byte_en) begin
			crc_q <= crc16_byte(crc_q, rx_byte);
			case (count_q)
				4'd0:    unit_ok_q  <= (rx_byte == unit_address);
				4'd1:    func_ok_q  <= (rx_byte == function_code);
				4'd2:    count_ok_q <= (rx_byte == COUNT_BYTE);
				default: ;
			endcase
			// saturate so long frames stay long
			if (count_q != COUNT_MAX) begin
				count_q <= count_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.byte_en && slot_hit) begin
			payload_q[slot[2:0]] <= rx_byte;
		end
	end

	always_comb begin
		if (count_q == 4'd0) begin
			status = ST_TIMEOUT;
		end else if (count_q != COUNT_FRAME) begin
			status = ST_LENGTH;
		end else if (crc_q != 16'h0000) begin
			status = ST_CRC;
		end else if (!unit_ok_q) begin
			status = ST_UNIT;
		end else if (!func_ok_q) begin
			status = ST_FUNCTION;
		end else if (!count_ok_q) begin
			status = ST_LENGTH;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		result.status = status;
		if (status == ST_OK) begin
			result.first_reading  = {payload_q[0], payload_q[1]};
			result.second_reading = {payload_q[2], payload_q[3]};
			result.third_reading  = {payload_q[4], payload_q[5]};
		end else begin
			result.first_reading  = '0;
			result.second_reading = '0;
			result.third_reading  = '0;
		end
	end

endmodule

// ===== rtl/modbus_response_frame_checker_top.sv =====
// Top level of the Modbus RTU read-registers reply checker.
// A word is registered at acceptance; a data word is applied in the next cycle, an
// end-of-frame word once the result register is free; its result is then registered
// and flagged on out_valid. Throughput: one word per cycle, but an end-of-frame word
// waits while a result is pending; the unrolled CRC byte update sets the cycle path.
// Reset clears the frame state, the CRC to all ones and both registers to 1 and 3.
module modbus_response_frame_checker_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mbrc_pkg::in_word_t   in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mbrc_pkg::out_word_t  out_word,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import mbrc_pkg::*;

	logic        in_valid_s1;
	in_word_t    in_word_s1;
	logic        out_valid_q;
	out_word_t   out_word_q;
	logic [7:0]  unit_q;
	logic [7:0]  func_q;
	logic        out_free;
	logic        advance_s1;
	logic        eof_s1;
	logic        cfg_wr;
	frame_ctl_t  ctl;
	out_word_t   result;

	assign out_free   = !out_valid_q || out_ready;
	assign eof_s1     = (in_word_s1.opcode == OP_EOF);
	// data words never wait; end of frame waits for the result register
	assign advance_s1 = in_valid_s1 && (!eof_s1 || out_free);
	assign in_ready   = !in_valid_s1 || advance_s1;

	assign ctl.byte_en = advance_s1 && !eof_s1;
	assign ctl.eof_en  = advance_s1 && eof_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_word_s1 <= in_word;
		end
	end

	mbrc_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.rx_byte       (in_word_s1.rx_byte),
		.unit_address  (unit_q),
		.function_code (func_q),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.eof_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.eof_en) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= UNIT_RESET[7:0];
			func_q <= FUNCTION_RESET[7:0];
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_UNIT:     unit_q <= pwdata[7:0];
				REG_FUNCTION: func_q <= pwdata[7:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_UNIT:     prdata = {24'h000000, unit_q};
			REG_FUNCTION: prdata = {24'h000000, func_q};
			default:      prdata = '0;
		endcase
	end

	a_result_from_eof: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid_s1 && eof_s1))
		else $error("result appeared without an end-of-frame word");

	a_byte_never_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !eof_s1) |-> in_ready)
		else $error("data word blocked the input");

	a_eof_waits_for_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && eof_s1 && out_valid && !out_ready) |=> (in_valid_s1 && eof_s1))
		else $error("end-of-frame word dropped while result pending");

	a_ok_has_full_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.eof_en && result.status == ST_OK) |=> (out_word.status == ST_OK))
		else $error("ok status lost in result register");

endmodule

// ===== dv/tb_modbus_response_frame_checker_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus RTU read-registers reply checker.
module tb_modbus_response_frame_checker_top;
	import mbrc_pkg::*;

	typedef enum {FR_GOOD, FR_UNIT, FR_FUNC, FR_COUNT, FR_CRC, FR_SHORT, FR_LONG, FR_EMPTY}
		frame_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_word_t    in_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_word;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// register shadows
	logic [7:0]  cfg_unit = 8'(UNIT_RESET);
	logic [7:0]  cfg_func = 8'(FUNCTION_RESET);

	// running frame state of the reply tracker
	logic [15:0] crc_run = CRC_START;
	logic [3:0]  rx_count = '0;
	logic        unit_hit = 1'b0;
	logic        func_hit = 1'b0;
	logic        count_hit = 1'b0;
	logic [7:0]  data_bytes [PAYLOAD_DEPTH];

	in_word_t    word_q [$];
	out_word_t   expected_replies [$];
	logic [7:0]  frame_buf [$];
	out_word_t   reply_exp;

	bit          steady_flow = 1'b0;
	int unsigned send_gap;
	int unsigned recv_stall;
	int unsigned recv_draw;
	int unsigned error_count = 0;

	modbus_response_frame_checker_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #5 clk = ~clk;

	// reflected CRC-16, one input bit at a time
	function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc, input logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = crc[0] ^ b[i];
			crc = crc >> 1;
			if (fb)
				crc = crc ^ 16'hA001;
		end
		return crc;
	endfunction

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want)
			note_error($sformatf("%s: expected %h, got %h", name, want, got));
	endtask

	// advance the reply tracker by one accepted word
	task automatic track_word(input in_word_t w);
		out_word_t r;
		if (w.opcode == OP_BYTE) begin
			crc_run = crc_fold_byte(crc_run, w.rx_byte);
			if (rx_count == 0)
				unit_hit = (w.rx_byte == cfg_unit);
			else if (rx_count == 1)
				func_hit = (w.rx_byte == cfg_func);
			else if (rx_count == 2)
				count_hit = (w.rx_byte == COUNT_BYTE);
			else if (rx_count < HEADER_BYTES + PAYLOAD_DEPTH)
				data_bytes[rx_count - HEADER_BYTES] = w.rx_byte;
			if (rx_count != COUNT_MAX)
				rx_count++;
		end else begin
			r = '0;
			if (rx_count == 0)
				r.status = ST_TIMEOUT;
			else if (rx_count != COUNT_FRAME)
				r.status = ST_LENGTH;
			else if (crc_run != 16'h0000)
				r.status = ST_CRC;
			else if (!unit_hit)
				r.status = ST_UNIT;
			else if (!func_hit)
				r.status = ST_FUNCTION;
			else if (!count_hit)
				r.status = ST_LENGTH;
			else
				r.status = ST_OK;
			if (r.status == ST_OK) begin
				r.first_reading  = {data_bytes[0], data_bytes[1]};
				r.second_reading = {data_bytes[2], data_bytes[3]};
				r.third_reading  = {data_bytes[4], data_bytes[5]};
			end
			expected_replies.push_back(r);
			crc_run = CRC_START;
			rx_count = '0;
			unit_hit = 1'b0;
			func_hit = 1'b0;
			count_hit = 1'b0;
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (word_q.size() != 0 || in_valid || expected_replies.size() != 0);
	endtask

	// write one register while the block is idle, then read it back
	task automatic write_register(input logic idx, input logic [7:0] value);
		wait_idle();
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= {24'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == REG_UNIT)
			cfg_unit = value;
		else
			cfg_func = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field(idx == REG_UNIT ? "unit_address readback" : "function_code readback",
			{24'h0, value}, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// build a reply frame of the given kind from the current register values
	task automatic build_frame(input frame_kind_t kind, input bit extreme);
		logic [15:0] crc;
		int n;
		frame_buf = {};
		if (kind != FR_EMPTY) begin
			frame_buf.push_back(kind == FR_UNIT ? cfg_unit ^ 8'($urandom_range(1, 255)) : cfg_unit);
			frame_buf.push_back(kind == FR_FUNC ? cfg_func ^ 8'($urandom_range(1, 255)) : cfg_func);
			frame_buf.push_back(kind == FR_COUNT ? COUNT_BYTE ^ 8'($urandom_range(1, 255))
				: COUNT_BYTE);
			for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
				if (extreme)
					frame_buf.push_back(i[0] ? 8'h00 : 8'hFF);
				else
					case ($urandom_range(0, 7))
						0: frame_buf.push_back(8'h00);
						1: frame_buf.push_back(8'hFF);
						default: frame_buf.push_back(8'($urandom));
					endcase
			end
			crc = CRC_START;
			foreach (frame_buf[i])
				crc = crc_fold_byte(crc, frame_buf[i]);
			// CRC goes out low byte first
			frame_buf.push_back(crc[7:0]);
			frame_buf.push_back(crc[15:8]);
			case (kind)
				FR_CRC: begin
					n = $urandom_range(0, FRAME_BYTES - 1);
					frame_buf[n] = frame_buf[n] ^ 8'(1 << $urandom_range(0, 7));
				end
				FR_SHORT: begin
					n = $urandom_range(1, FRAME_BYTES - 1);
					while (frame_buf.size() > n)
						void'(frame_buf.pop_back());
				end
				FR_LONG: repeat ($urandom_range(1, 9)) frame_buf.push_back(8'($urandom));
				default: ;
			endcase
		end
	endtask

	task automatic load_frame();
		@(negedge clk);
		foreach (frame_buf[i])
			word_q.push_back(in_word_t'{opcode: OP_BYTE, rx_byte: frame_buf[i]});
		word_q.push_back(in_word_t'{opcode: OP_EOF, rx_byte: 8'($urandom)});
	endtask

	// sender: one word per handshake, random gap before each next word except in steady flow
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				track_word(in_word);
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (word_q.size() != 0) begin
					in_word <= word_q.pop_front();
					in_valid <= 1'b1;
					send_gap <= steady_flow ? 0 : $urandom_range(0, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each reply word, then stall for a random while except in steady flow
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall <= 0;
		end else if (out_valid && out_ready) begin
			if (expected_replies.size() == 0) begin
				note_error($sformatf("reply word with none expected: %h", out_word));
			end else begin
				reply_exp = expected_replies.pop_front();
				check_field("status", reply_exp.status, out_word.status);
				check_field("first_reading", reply_exp.first_reading, out_word.first_reading);
				check_field("second_reading", reply_exp.second_reading, out_word.second_reading);
				check_field("third_reading", reply_exp.third_reading, out_word.third_reading);
			end
			recv_draw = steady_flow ? 0 : $urandom_range(0, 5);
			recv_stall <= recv_draw;
			out_ready <= (recv_draw == 0);
		end else if (recv_stall != 0) begin
			recv_stall <= recv_stall - 1;
			out_ready <= (recv_stall == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		logic [7:0] unit_set [6];
		logic [7:0] func_set [6];
		frame_kind_t kind;
		int unsigned pick;
		unit_set = '{8'h00, 8'hFF, 8'h01, 8'hFF, 8'h5A, 8'h00};
		func_set = '{8'h00, 8'hFF, 8'h03, 8'h00, 8'hA5, 8'hFF};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty frame, good frame with extreme data, one-byte frame
		build_frame(FR_EMPTY, 1'b0);
		load_frame();
		build_frame(FR_GOOD, 1'b1);
		load_frame();
		build_frame(FR_SHORT, 1'b0);
		while (frame_buf.size() > 1)
			void'(frame_buf.pop_back());
		load_frame();

		// unit byte is judged against the address in force when it arrives
		build_frame(FR_GOOD, 1'b0);
		@(negedge clk);
		word_q.push_back(in_word_t'{opcode: OP_BYTE, rx_byte: frame_buf.pop_front()});
		write_register(REG_UNIT, 8'h7E);
		load_frame();

		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 4) begin
				unit_set[phase] = 8'($urandom);
				func_set[phase] = 8'($urandom);
			end
			write_register(REG_UNIT, unit_set[phase]);
			write_register(REG_FUNCTION, func_set[phase]);
			steady_flow = (phase == 2);
			for (int f = 0; f < 6; f++) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					kind = FR_GOOD;
				else if (pick < 61)
					kind = FR_UNIT;
				else if (pick < 67)
					kind = FR_FUNC;
				else if (pick < 73)
					kind = FR_COUNT;
				else if (pick < 81)
					kind = FR_CRC;
				else if (pick < 89)
					kind = FR_SHORT;
				else if (pick < 96)
					kind = FR_LONG;
				else
					kind = FR_EMPTY;
				build_frame(kind, 1'b0);
				load_frame();
				// hold the sender until every reply is back
				if (f == 2)
					wait_idle();
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/mbrc_pkg.sv
rtl/mbrc_frame.sv
rtl/modbus_response_frame_checker_top.sv
dv/tb_modbus_response_frame_checker_top.sv
